FILE: src/pbaln_pkg.sv
package pbaln_pkg;

    localparam int MaxRecordBytes = 65536;
    localparam int NestDepth      = 4;

    typedef enum logic [3:0] {
        EV_SEQ        = 4'd0,
        EV_QUAL       = 4'd1,
        EV_MAPQ       = 4'd2,
        EV_MAP_START  = 4'd3,
        EV_NODE       = 4'd4,
        EV_OFFSET     = 4'd5,
        EV_REVERSE    = 4'd6,
        EV_EDIT_START = 4'd7,
        EV_FROM_LEN   = 4'd8,
        EV_TO_LEN     = 4'd9,
        EV_EDIT_SEQ   = 4'd10,
        EV_REC_END    = 4'd11,
        EV_ERR_TRUNC  = 4'd12,
        EV_ERR_LONG   = 4'd13,
        EV_ERR_WIRE   = 4'd14,
        EV_ERR_FIELD  = 4'd15
    } event_kind_t;

    typedef enum logic [2:0] {
        CTX_ALIGN = 3'd0,
        CTX_PATH  = 3'd1,
        CTX_MAP   = 3'd2,
        CTX_POS   = 3'd3,
        CTX_EDIT  = 3'd4
    } context_t;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_VAL   = 2'd1,
        PH_LEN   = 2'd2,
        PH_BYTES = 2'd3
    } phase_t;

    // What the parser hands to the emitter for one accepted byte.
    typedef struct packed {
        logic        has_ev;
        event_kind_t ev_kind;
        logic [63:0] ev_val;
        logic        has_end;
    } entry_t;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

FILE: src/pbaln_parser.sv
module pbaln_parser #(
    parameter int MAX_RECORD_BYTES = pbaln_pkg::MaxRecordBytes,
    parameter int NEST_DEPTH       = pbaln_pkg::NestDepth,
    parameter int OW               = $clog2(MAX_RECORD_BYTES + 1) + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              ent_valid,
    output pbaln_pkg::entry_t ent
);
    localparam int LW = $clog2(NEST_DEPTH);

    logic [OW-1:0]           byte_offset_reg;
    logic [OW-1:0]           end_reg [NEST_DEPTH];
    pbaln_pkg::context_t     ctx_reg [NEST_DEPTH];
    logic [LW-1:0]           level_reg;
    pbaln_pkg::phase_t       phase_reg;
    logic [63:0]             acc_reg;
    logic [3:0]              cnt_reg;
    logic [60:0]             field_reg;
    logic [2:0]              wire_reg;
    logic [OW-1:0]           skip_reg;
    logic                    err_reg;

    logic [OW-1:0]           byte_offset_next;
    logic [OW-1:0]           end_next [NEST_DEPTH];
    pbaln_pkg::context_t     ctx_next [NEST_DEPTH];
    logic [LW-1:0]           level_next;
    pbaln_pkg::phase_t       phase_next;
    logic [63:0]             acc_next;
    logic [3:0]              cnt_next;
    logic [60:0]             field_next;
    logic [2:0]              wire_next;
    logic [OW-1:0]           skip_next;
    logic                    err_next;

    logic                    out_v;
    pbaln_pkg::entry_t       out_e;

    always_comb
    begin
        logic [OW-1:0] p;
        logic [OW-1:0] lim;
        logic [OW-1:0] room;
        pbaln_pkg::context_t ctx;
        pbaln_pkg::context_t child;
        logic has_child;
        logic [3:0] c;
        logic [63:0] v;
        logic [63:0] shifted;
        logic [3:0] err;
        logic has_ev;
        pbaln_pkg::event_kind_t kind;
        logic [63:0] val;
        logic [OW-1:0] s;
        logic [LW-1:0] lv;
        logic clear;

        byte_offset_next = byte_offset_reg;
        end_next   = end_reg;
        ctx_next   = ctx_reg;
        level_next = level_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        skip_next  = skip_reg;
        err_next   = err_reg;
        out_v = 1'b0;
        out_e = '0;
        err = 4'd0;
        has_ev = 1'b0;
        kind = pbaln_pkg::EV_SEQ;
        val = '0;
        child = pbaln_pkg::CTX_ALIGN;
        has_child = 1'b0;
        clear = 1'b0;
        v = '0;
        s = '0;
        shifted = '0;
        c = cnt_reg;
        lv = level_reg;

        p = byte_offset_reg + OW'(1);
        lim = (level_reg != '0) ? end_reg[level_reg] : OW'(MAX_RECORD_BYTES);
        if (lim < p) lim = p;
        room = lim - p;
        ctx = ctx_reg[level_reg];

        if (err_reg) begin
            if (last_byte) clear = 1'b1;
        end else begin
            if (phase_reg == pbaln_pkg::PH_BYTES) begin
                if (wire_reg == 3'd2) begin
                    if (ctx == pbaln_pkg::CTX_ALIGN && field_reg == 61'd1) begin
                        has_ev = 1'b1; kind = pbaln_pkg::EV_SEQ;
                    end else if (ctx == pbaln_pkg::CTX_ALIGN && field_reg == 61'd4) begin
                        has_ev = 1'b1; kind = pbaln_pkg::EV_QUAL;
                    end else if (ctx == pbaln_pkg::CTX_EDIT && field_reg == 61'd3) begin
                        has_ev = 1'b1; kind = pbaln_pkg::EV_EDIT_SEQ;
                    end
                    val = {56'd0, data_byte};
                end
                if (skip_reg != '0) skip_next = skip_reg - OW'(1);
                if (skip_next == '0) phase_next = pbaln_pkg::PH_KEY;
            end else begin
                if (c > 4'd9) c = 4'd9;
                // Seven payload bits per varint byte; the shift is a 10-way select.
                shifted = {57'd0, data_byte[6:0]} << (7 * c);
                v = acc_reg | shifted;
                acc_next = v;
                cnt_next = c + 4'd1;
                if (data_byte[7]) begin
                    if (cnt_next >= 4'd10) err = pbaln_pkg::EV_ERR_LONG;
                end else begin
                    acc_next = '0;
                    cnt_next = '0;
                    unique case (phase_reg)
                        pbaln_pkg::PH_KEY:
                        begin
                            field_next = v[63:3];
                            wire_next = v[2:0];
                            if (v[2:0] == 3'd0) phase_next = pbaln_pkg::PH_VAL;
                            else if (v[2:0] == 3'd2) phase_next = pbaln_pkg::PH_LEN;
                            else if (v[2:0] == 3'd1 || v[2:0] == 3'd5) begin
                                s = (v[2:0] == 3'd1) ? OW'(8) : OW'(4);
                                if (s > room) err = pbaln_pkg::EV_ERR_FIELD;
                                else begin
                                    skip_next = s;
                                    phase_next = pbaln_pkg::PH_BYTES;
                                end
                            end else err = pbaln_pkg::EV_ERR_WIRE;
                        end
                        pbaln_pkg::PH_VAL:
                        begin
                            phase_next = pbaln_pkg::PH_KEY;
                            val = v;
                            if (ctx == pbaln_pkg::CTX_ALIGN && field_reg == 61'd5) begin
                                has_ev = 1'b1; kind = pbaln_pkg::EV_MAPQ;
                                val = pbaln_pkg::sext32(v);
                            end else if (ctx == pbaln_pkg::CTX_POS && field_reg == 61'd1) begin
                                has_ev = 1'b1; kind = pbaln_pkg::EV_NODE;
                            end else if (ctx == pbaln_pkg::CTX_POS && field_reg == 61'd2) begin
                                has_ev = 1'b1; kind = pbaln_pkg::EV_OFFSET;
                            end else if (ctx == pbaln_pkg::CTX_POS && field_reg == 61'd4) begin
                                has_ev = 1'b1; kind = pbaln_pkg::EV_REVERSE;
                                val = {63'd0, v != 64'd0};
                            end else if (ctx == pbaln_pkg::CTX_EDIT && field_reg == 61'd1) begin
                                has_ev = 1'b1; kind = pbaln_pkg::EV_FROM_LEN;
                                val = pbaln_pkg::sext32(v);
                            end else if (ctx == pbaln_pkg::CTX_EDIT && field_reg == 61'd2) begin
                                has_ev = 1'b1; kind = pbaln_pkg::EV_TO_LEN;
                                val = pbaln_pkg::sext32(v);
                            end
                        end
                        default:
                        begin
                            if (v > {{(64-OW){1'b0}}, room}) begin
                                err = pbaln_pkg::EV_ERR_FIELD;
                            end else begin
                                if (ctx == pbaln_pkg::CTX_ALIGN && field_reg == 61'd2) begin
                                    has_child = 1'b1; child = pbaln_pkg::CTX_PATH;
                                end else if (ctx == pbaln_pkg::CTX_PATH && field_reg == 61'd2) begin
                                    has_child = 1'b1; child = pbaln_pkg::CTX_MAP;
                                end else if (ctx == pbaln_pkg::CTX_MAP && field_reg == 61'd1) begin
                                    has_child = 1'b1; child = pbaln_pkg::CTX_POS;
                                end else if (ctx == pbaln_pkg::CTX_MAP && field_reg == 61'd2) begin
                                    has_child = 1'b1; child = pbaln_pkg::CTX_EDIT;
                                end
                                if (has_child && level_reg != LW'(NEST_DEPTH - 1)) begin
                                    lv = level_reg + LW'(1);
                                    end_next[lv] = p + v[OW-1:0];
                                    ctx_next[lv] = child;
                                    phase_next = pbaln_pkg::PH_KEY;
                                    if (child == pbaln_pkg::CTX_MAP) begin
                                        has_ev = 1'b1; kind = pbaln_pkg::EV_MAP_START;
                                        val = '0;
                                    end
                                    if (child == pbaln_pkg::CTX_EDIT) begin
                                        has_ev = 1'b1; kind = pbaln_pkg::EV_EDIT_START;
                                        val = '0;
                                    end
                                end else if (v == 64'd0) begin
                                    phase_next = pbaln_pkg::PH_KEY;
                                end else begin
                                    skip_next = v[OW-1:0];
                                    phase_next = pbaln_pkg::PH_BYTES;
                                end
                            end
                        end
                    endcase
                end
            end

            // Pop every level whose end falls on this byte, at most NEST_DEPTH-1 steps; mid-field it is truncation.
            if (err == 4'd0) begin
                if (phase_next == pbaln_pkg::PH_KEY && cnt_next == 4'd0) begin
                    for (int i = NEST_DEPTH - 1; i > 0; i--) begin
                        if (lv == LW'(i) && end_next[i] == p) lv = LW'(i - 1);
                    end
                end else if (lv != '0 && end_next[lv] == p) begin
                    err = pbaln_pkg::EV_ERR_TRUNC;
                end
            end
            level_next = lv;
            if (last_byte) begin
                if (lv != '0 && end_next[1] > p) err = pbaln_pkg::EV_ERR_FIELD;
                else if (err == 4'd0 && (phase_next != pbaln_pkg::PH_KEY || cnt_next != 4'd0))
                    err = (phase_next == pbaln_pkg::PH_BYTES) ? pbaln_pkg::EV_ERR_FIELD
                                                              : pbaln_pkg::EV_ERR_TRUNC;
            end else if (err == 4'd0 && p >= OW'(MAX_RECORD_BYTES)) begin
                err = pbaln_pkg::EV_ERR_FIELD;
            end

            if (err != 4'd0) begin
                out_v = 1'b1;
                out_e.has_ev = 1'b1;
                out_e.ev_kind = pbaln_pkg::event_kind_t'(err);
                out_e.ev_val = '0;
                if (last_byte) clear = 1'b1;
                else begin
                    byte_offset_next = p;
                    err_next = 1'b1;
                end
            end else begin
                out_e.has_ev = has_ev;
                out_e.ev_kind = kind;
                out_e.ev_val = val;
                out_e.has_end = last_byte;
                out_v = has_ev || last_byte;
                if (last_byte) clear = 1'b1;
                else byte_offset_next = p;
            end
        end

        if (clear) begin
            byte_offset_next = '0;
            for (int i = 0; i < NEST_DEPTH; i++) begin
                end_next[i] = '0;
                ctx_next[i] = pbaln_pkg::CTX_ALIGN;
            end
            level_next = '0;
            phase_next = pbaln_pkg::PH_KEY;
            acc_next = '0;
            cnt_next = '0;
            field_next = '0;
            wire_next = '0;
            skip_next = '0;
            err_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_offset_reg <= '0;
            for (int i = 0; i < NEST_DEPTH; i++) begin
                end_reg[i] <= '0;
                ctx_reg[i] <= pbaln_pkg::CTX_ALIGN;
            end
            level_reg <= '0;
            phase_reg <= pbaln_pkg::PH_KEY;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            field_reg <= '0;
            wire_reg  <= '0;
            skip_reg  <= '0;
            err_reg   <= 1'b0;
        end else if (step) begin
            byte_offset_reg <= byte_offset_next;
            end_reg   <= end_next;
            ctx_reg   <= ctx_next;
            level_reg <= level_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
            skip_reg  <= skip_next;
            err_reg   <= err_next;
        end
    end

    assign ent_valid = step && out_v;
    assign ent = out_e;

endmodule

FILE: src/pbaln_queue.sv
module pbaln_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pbaln_pkg::entry_t push_data,
    input  logic              pop,
    output logic              not_empty,
    output logic              has_space,
    output pbaln_pkg::entry_t head
);
    pbaln_pkg::entry_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign not_empty = (count_reg != 2'd0);
    // Room is judged with the pop of this cycle counted, so a full queue still flows.
    assign has_space = (count_reg != 2'd2) || pop;
    assign head = mem_reg[rptr_reg];

endmodule

FILE: src/pbaln_emitter.sv
module pbaln_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ent_valid,
    input  pbaln_pkg::entry_t ent,
    output logic              ent_pop,
    output logic              valid,
    input  logic              ready,
    output logic [3:0]        event_kind,
    output logic [63:0]       event_value,
    output logic              last_of_run
);
    // Set once the first of two results of the head entry has gone out.
    logic sent_first_reg;
    logic two;
    logic fire;

    assign two  = ent.has_ev && ent.has_end;
    assign valid = ent_valid;
    assign fire = valid && ready;

    always_comb
    begin
        if (ent.has_ev && !sent_first_reg) begin
            event_kind  = ent.ev_kind;
            event_value = ent.ev_val;
            last_of_run = !ent.has_end;
        end else begin
            event_kind  = pbaln_pkg::EV_REC_END;
            event_value = '0;
            last_of_run = 1'b1;
        end
    end

    assign ent_pop = fire && (!two || sent_first_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) sent_first_reg <= 1'b0;
        else if (fire) sent_first_reg <= two && !sent_first_reg;
    end

endmodule

FILE: src/protobuf_alignment_field_parser.sv
// Streaming parser for one serialized alignment record, one byte per transaction.
// Input channel: in_valid/in_ready with data_byte and last_byte (last byte of record).
// Output channel: out_valid/out_ready with event_kind, event_value and last_of_run.
// A byte is decoded in the cycle it is accepted; its results are written into a
// two-entry queue, whose head drives the output. A byte that yields
// two results (an event plus record end) holds the output for two transactions.
// Throughput is one byte per cycle while the output keeps up; the queue depth
// and the two-result bytes set when in_ready drops.
// Bytes that yield no result leave the queue untouched.
// After reset the parser expects the first key of a new record; no memory
// clearing is needed. If the receiver stalls, results wait in the queue and
// in_ready falls once the queue is full; no result is lost.
module protobuf_alignment_field_parser #(
    parameter int MAX_RECORD_BYTES = pbaln_pkg::MaxRecordBytes,
    parameter int NEST_DEPTH       = pbaln_pkg::NestDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_kind,
    output logic [63:0] event_value,
    output logic        last_of_run
);
    logic              step;
    logic              push;
    pbaln_pkg::entry_t push_data;
    logic              q_pop, q_not_empty, q_space;
    pbaln_pkg::entry_t q_head;

    assign in_ready = q_space;
    assign step = in_valid && in_ready;

    pbaln_parser #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
        .NEST_DEPTH(NEST_DEPTH)
    ) u_parser (
        .clk(clk), .rst_n(rst_n), .step(step),
        .data_byte(data_byte), .last_byte(last_byte),
        .ent_valid(push), .ent(push_data)
    );

    pbaln_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .pop(q_pop), .not_empty(q_not_empty), .has_space(q_space), .head(q_head)
    );

    pbaln_emitter u_emit (
        .clk(clk), .rst_n(rst_n), .ent_valid(q_not_empty), .ent(q_head),
        .ent_pop(q_pop), .valid(out_valid), .ready(out_ready),
        .event_kind(event_kind), .event_value(event_value), .last_of_run(last_of_run)
    );

endmodule

FILE: src/pbaln_checker.sv
module pbaln_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  event_kind,
    input logic [63:0] event_value,
    input logic        last_of_run
);
    // Record end always closes a run.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == pbaln_pkg::EV_REC_END |-> last_of_run)
        else $error("record end without last_of_run");

    // Errors close the run and carry zero.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind[3:2] == 2'b11 |-> last_of_run && event_value == 64'd0)
        else $error("error result malformed");

    // A result that is not last is followed by the record end.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid
        && event_kind == pbaln_pkg::EV_REC_END)
        else $error("first of a pair not followed by record end");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(event_value))
        else $error("stalled result changed");

    // The input only stalls while results are waiting on the output.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with no result pending");
endmodule

bind protobuf_alignment_field_parser pbaln_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .event_kind(event_kind),
    .event_value(event_value), .last_of_run(last_of_run)
);
